FILE: design/mois_pkg.sv
// ----------------------------------------------------------------------------
// mois_pkg: shared definitions for the most-overdue item scheduler
// Sizes, item period table and the stamp-memory port bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mois_pkg;

  localparam int NUM_ITEMS = 12;   // 1 .. 16
  localparam int TIME_BITS = 32;   // 16 .. 32
  localparam int IDX_W     = 4;
  localparam int MASK_W    = 12;
  localparam int SCORE_W   = 32;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SCORE_W-1:0]   score_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    time_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } ram_rd_t;

  // item period in microseconds; items beyond the table have none
  function automatic score_t period_us(input idx_t idx);
    score_t p;
    case (idx)
      4'd0:    p = 32'd300000;
      4'd1:    p = 32'd600000;
      4'd2:    p = 32'd100000;
      4'd3:    p = 32'd100000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd1500000;
      4'd6:    p = 32'd850000;
      4'd7:    p = 32'd850000;
      4'd8:    p = 32'd850000;
      4'd9:    p = 32'd850000;
      4'd10:   p = 32'd850000;
      4'd11:   p = 32'd850000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/mois_stamp_ram.sv
// ----------------------------------------------------------------------------
// mois_stamp_ram: last-send time store
// One write port, one read port, registered read data. Entries never written
// since reset read as zero via per-entry valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mois_stamp_ram (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mois_pkg::ram_wr_t wr,
  input  wire mois_pkg::ram_rd_t rd,
  output      mois_pkg::time_t   rd_data
);
  import mois_pkg::*;

  time_t                mem [NUM_ITEMS];
  logic [NUM_ITEMS-1:0] vld_r;
  time_t                rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd.en) begin
      rd_vld_r <= vld_r[rd.addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

FILE: design/most_overdue_item_scheduler.sv
// ----------------------------------------------------------------------------
// most_overdue_item_scheduler: picks the most overdue ready item each tick
//
//   channel | direction | ports
//   in      | sink      | in_valid, in_ready, in_now_us, in_ready_mask, in_send_ok
//   out     | source    | out_valid, out_ready, out_sent_valid, out_sent_item,
//           |           | out_next_valid, out_next_item
//
// A word is taken only in idle, where the last scheduled item is stamped.
// A scan reads one stamp per cycle, then the score pipe drains, and the result
// is registered once the output register is free; the block then returns to
// idle for the next word. Reset clears the schedule and marks every stamp as
// zero at once. A stalled result only holds the block once the next scan is
// finished.
// ----------------------------------------------------------------------------
`default_nettype none

module most_overdue_item_scheduler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [31:0]                in_now_us,
  input  wire logic [mois_pkg::MASK_W-1:0] in_ready_mask,
  input  wire logic                       in_send_ok,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic                       out_sent_valid,
  output      mois_pkg::idx_t             out_sent_item,
  output      logic                       out_next_valid,
  output      mois_pkg::idx_t             out_next_item
);
  import mois_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic              accept, out_free, scan_last;
  idx_t              rd_idx_r;
  time_t             now_r;
  logic [MASK_W-1:0] mask_r;
  logic              sent_vld_r;
  idx_t              sent_item_r;
  logic              sched_vld_r;
  idx_t              sched_idx_r;
  ram_wr_t           wr;
  ram_rd_t           rd;
  time_t             rd_data;
  logic              p1_vld_r, p2_vld_r;
  idx_t              p1_idx_r, p2_idx_r;
  time_t             elapsed;
  score_t            score_nxt, score_r;
  logic              cand;
  logic              best_found_r;
  idx_t              best_idx_r;
  score_t            best_score_r;
  logic              out_valid_r, out_sent_valid_r, out_next_valid_r;
  idx_t              out_sent_item_r, out_next_item_r;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_last = (rd_idx_r == IDX_W'(NUM_ITEMS - 1));

  // stamp the item chosen last tick, then read every entry in turn
  always_comb begin
    wr.en   = accept && sched_vld_r;
    wr.addr = sched_idx_r;
    wr.data = in_now_us[TIME_BITS-1:0];
    rd.en   = (state_r == S_SCAN);
    rd.addr = rd_idx_r;
  end

  mois_stamp_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (scan_last) state_nxt = S_FLUSH;
      S_FLUSH: if (!p1_vld_r && !p2_vld_r) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx_r <= '0;
    end else if (rd.en) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r       <= in_now_us[TIME_BITS-1:0];
      mask_r      <= in_ready_mask;
      sent_vld_r  <= sched_vld_r && in_send_ok;
      sent_item_r <= (sched_vld_r && in_send_ok) ? sched_idx_r : '0;
    end
  end

  // score = elapsed - period, wrapping signed
  assign elapsed   = now_r - rd_data;
  assign score_nxt = SCORE_W'(elapsed) - period_us(p1_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= rd.en;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= rd_idx_r;
    p2_idx_r <= p1_idx_r;
    score_r  <= score_nxt;
  end

  assign cand = p2_vld_r && (32'(p2_idx_r) < MASK_W) && mask_r[p2_idx_r];

  // strict compare in ascending order keeps the lower index on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
    end else if (accept) begin
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
    end else if (cand && (!best_found_r || $signed(score_r) > $signed(best_score_r))) begin
      best_found_r <= 1'b1;
      best_idx_r   <= p2_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cand && (!best_found_r || $signed(score_r) > $signed(best_score_r))) begin
      best_score_r <= score_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_vld_r <= 1'b0;
      sched_idx_r <= '0;
    end else if (state_r == S_OUT && out_free) begin
      sched_vld_r <= best_found_r;
      sched_idx_r <= best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_sent_valid_r <= sent_vld_r;
      out_sent_item_r  <= sent_item_r;
      out_next_valid_r <= best_found_r;
      out_next_item_r  <= best_idx_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sent_valid = out_sent_valid_r;
  assign out_sent_item  = out_sent_item_r;
  assign out_next_valid = out_next_valid_r;
  assign out_next_item  = out_next_item_r;

`ifndef SYNTH
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!p1_vld_r && !p2_vld_r))
    else $error("read pipeline busy while idle");

  a_stamp_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_IDLE) && !rd.en)
    else $error("stamp write outside the accept cycle");

  a_sched_range: assert property (@(posedge clk) disable iff (!rst_n)
    sched_vld_r |-> (32'(sched_idx_r) < NUM_ITEMS))
    else $error("scheduled index out of range");

  a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_next_valid) |-> (out_next_item == '0))
    else $error("next item not zero when nothing scheduled");

  a_sent_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (!out_sent_valid || $past(sched_vld_r, 1) ||
                                        out_sent_item == '0))
    else $error("sent item without a schedule");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_most_overdue_item_scheduler.sv
// ----------------------------------------------------------------------------
// tb_most_overdue_item_scheduler: self-checking bench for the item scheduler
// A short table of hand-picked ticks is followed by about 1600 random ticks.
// Most random ticks step time like a live 10 ms tick; the rest jump, wrap or
// scramble it. Typed rows are checked against hand-written results, others
// against the bench's scoring model. Both handshakes idle at random, and the
// result side holds off for long stretches so that the input backs up.
// ----------------------------------------------------------------------------
module tb_most_overdue_item_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import mois_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int SCAN_CYCLES     = NUM_ITEMS + 5;
  localparam int DRAIN_CYCLES    = 4 * SCAN_CYCLES;
  localparam int RANDOM_TICKS    = 1600;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_PRINTED     = 40;

  typedef struct packed {
    logic sent_valid;
    idx_t sent_item;
    logic next_valid;
    idx_t next_item;
  } tick_result_t;

  typedef struct packed {
    logic [31:0]       now;
    logic [MASK_W-1:0] mask;
    logic              ok;
    logic              typed;
    tick_result_t      want;
  } tick_word_t;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [31:0]       in_now_us     = '0;
  logic [MASK_W-1:0] in_ready_mask = '0;
  logic              in_send_ok    = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic              out_sent_valid;
  idx_t              out_sent_item;
  logic              out_next_valid;
  idx_t              out_next_item;

  // scoring model state
  time_t       stamp_us [NUM_ITEMS];
  idx_t        due_idx;
  logic        due_present;
  int unsigned period_ms_of [16] = '{300, 600, 100, 100, 100, 1500, 850, 850,
                                     850, 850, 850, 850, 0, 0, 0, 0};

  tick_result_t expected_ticks [$];
  tick_word_t   directed_ticks [$];
  logic [31:0]  now_run     = '0;
  bit           quiet_tx    = 1'b0;
  int           cycle_count = 0;
  int           mismatches  = 0;
  int           results_seen = 0;

  most_overdue_item_scheduler u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_now_us      (in_now_us),
    .in_ready_mask  (in_ready_mask),
    .in_send_ok     (in_send_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sent_valid (out_sent_valid),
    .out_sent_item  (out_sent_item),
    .out_next_valid (out_next_valid),
    .out_next_item  (out_next_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  // Stamp the item scheduled last tick, then pick the highest signed score.
  function automatic tick_result_t schedule_tick(input logic [31:0] now_us,
                                                 input logic [MASK_W-1:0] mask,
                                                 input logic ok);
    tick_result_t       r;
    time_t              now_t;
    time_t              elapsed;
    logic [31:0]        wide;
    logic signed [31:0] score;
    logic signed [31:0] top_score;
    logic               found;
    idx_t               top_idx;
    r         = '0;
    found     = 1'b0;
    top_idx   = '0;
    top_score = '0;
    now_t     = now_us[TIME_BITS-1:0];
    if (due_present) begin
      stamp_us[due_idx] = now_t;
      if (ok) begin
        r.sent_valid = 1'b1;
        r.sent_item  = due_idx;
      end
    end
    for (int i = 0; i < NUM_ITEMS && i < MASK_W; i++) begin
      if (mask[i]) begin
        elapsed = now_t - stamp_us[i];
        wide    = '0;
        wide[TIME_BITS-1:0] = elapsed;
        score   = $signed(wide - period_ms_of[i] * 32'd1000);
        // strict compare: a tie keeps the lower index
        if (!found || score > top_score) begin
          found     = 1'b1;
          top_score = score;
          top_idx   = idx_t'(i);
        end
      end
    end
    due_present  = found;
    due_idx      = top_idx;
    r.next_valid = found;
    r.next_item  = top_idx;
    return r;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic tick_word_t random_tick();
    tick_word_t w;
    int         roll;
    w    = '0;
    roll = $urandom_range(0, 99);
    if (roll < 75) now_run = now_run + $urandom_range(5000, 15000);
    else if (roll < 85) now_run = now_run + $urandom_range(0, 3000000);
    else if (roll < 95) now_run = $urandom;
    else now_run = 32'hFFFF_FFFF - $urandom_range(0, 40000);
    w.now = now_run;
    roll  = $urandom_range(0, 99);
    if (roll < 45) w.mask = '1;
    else if (roll < 85) w.mask = MASK_W'($urandom);
    else if (roll < 95) w.mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
    else w.mask = '0;
    w.ok = ($urandom_range(0, 9) != 0);
    return w;
  endfunction

  task automatic add_row(input logic [31:0] now, input logic [MASK_W-1:0] mask,
                         input logic ok, input logic typed,
                         input logic sv, input int si, input logic nv, input int ni);
    tick_word_t w;
    w.now   = now;
    w.mask  = mask;
    w.ok    = ok;
    w.typed = typed;
    w.want  = '{sv, idx_t'(si), nv, idx_t'(ni)};
    directed_ticks.push_back(w);
  endtask

  task automatic send_tick(input tick_word_t w);
    tick_result_t r;
    int           gap;
    in_valid      <= 1'b1;
    in_now_us     <= w.now;
    in_ready_mask <= w.mask;
    in_send_ok    <= w.ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = schedule_tick(w.now, w.mask, w.ok);
    expected_ticks.push_back(w.typed ? w.want : r);
    gap = quiet_tx ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_ITEMS; i++) stamp_us[i] = '0;
    due_idx     = '0;
    due_present = 1'b0;

    //       now            mask     ok  typed sv si nv ni
    add_row(32'h0000_0000, 12'h000, 1'b0, 1'b1, 0, 0, 0, 0);  // idle after reset
    add_row(32'h0000_0000, 12'hFFF, 1'b1, 1'b1, 0, 0, 1, 2);  // shortest period, low index
    add_row(32'h8004_93E0, 12'h001, 1'b1, 1'b1, 1, 2, 1, 0);  // most negative score
    add_row(32'h8010_0000, 12'h000, 1'b0, 1'b1, 0, 0, 0, 0);  // encode fails
    add_row(32'hFFFF_FFFF, 12'h800, 1'b1, 1'b1, 0, 0, 1, 11); // nothing was scheduled
    add_row(32'h0000_0000, 12'hFFF, 1'b1, 1'b0, 0, 0, 0, 0);  // time wraps
    add_row(32'h0000_0000, 12'hFC0, 1'b1, 1'b0, 0, 0, 0, 0);  // tie across equal periods
    add_row(32'h7FFF_FFFF, 12'h555, 1'b0, 1'b0, 0, 0, 0, 0);
    add_row(32'hAAAA_AAAA, 12'hAAA, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h5555_5555, 12'h555, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h0000_0001, 12'hFFF, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h0001_86A0, 12'h01C, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h0001_ADB0, 12'h020, 1'b0, 1'b0, 0, 0, 0, 0);
    add_row(32'h0010_0000, 12'h000, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h0010_0000, 12'h000, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h8000_0000, 12'h3FF, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h1234_5678, 12'hFFF, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32'h1234_5678, 12'hFFF, 1'b1, 1'b0, 0, 0, 0, 0);  // zero elapsed on the sent item
    add_row(32'hEDCB_A987, 12'h801, 1'b0, 1'b0, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ticks[k]) send_tick(directed_ticks[k]);
    for (int n = 0; n < RANDOM_TICKS; n++) begin
      quiet_tx = ((n / 150) % 4 == 2);
      send_tick(random_tick());
    end
    in_valid <= 1'b0;

    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : result_side
    int           stall_left;
    bit           quiet_rx;
    tick_result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          note_mismatch("result word with no tick pending");
        end else begin
          want = expected_ticks.pop_front();
          if (out_sent_valid !== want.sent_valid)
            note_mismatch($sformatf("sent_valid %b, want %b", out_sent_valid, want.sent_valid));
          if (out_sent_item !== want.sent_item)
            note_mismatch($sformatf("sent_item %0d, want %0d", out_sent_item, want.sent_item));
          if (out_next_valid !== want.next_valid)
            note_mismatch($sformatf("next_valid %b, want %b", out_next_valid, want.next_valid));
          if (out_next_item !== want.next_item)
            note_mismatch($sformatf("next_item %0d, want %0d", out_next_item, want.next_item));
        end
        results_seen++;
        // long hold-off so the block fills and blocks its input
        if (results_seen == 100 || results_seen == 900) stall_left = HOLD_OFF_CYCLES;
      end
      quiet_rx = ((cycle_count / 400) % 4 == 1);
      if (stall_left == 0 && !quiet_rx && $urandom_range(0, 7) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
design/mois_pkg.sv
design/mois_stamp_ram.sv
design/most_overdue_item_scheduler.sv
dv/tb_most_overdue_item_scheduler.sv
